[design/rphp_pkg.sv]
// rphp_pkg: shared types and constants for the resource package header parser
// holds the result record type, result kinds, marker bytes and phase codes
// no dependencies
`timescale 1ns / 1ps

package rphp_pkg;

  localparam logic [7:0] MARK_FIRST  = 8'hFE;
  localparam logic [7:0] MARK_SECOND = 8'h01;

  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_CORRUPT = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  localparam logic [2:0] PH_SCAN     = 3'd0;
  localparam logic [2:0] PH_INDEX    = 3'd1;
  localparam logic [2:0] PH_PACKED   = 3'd2;
  localparam logic [2:0] PH_UNPACKED = 3'd3;
  localparam logic [2:0] PH_NAMELEN  = 3'd4;
  localparam logic [2:0] PH_NAME     = 3'd5;
  localparam logic [2:0] PH_TERM     = 3'd6;
  localparam logic [2:0] PH_PAYLOAD  = 3'd7;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] resource_index;
    logic        header_ok;
    logic [31:0] packed_size;
    logic [31:0] unpacked_size;
    logic [31:0] name_length;
    logic        name_terminated;
    logic [31:0] name_offset;
    logic [31:0] payload_offset;
    logic [31:0] event_offset;
    logic        last_of_run;
  } result_t;

endpackage

[design/rphp_core.sv]
// rphp_core: byte parser state and per-byte result generation
// produces up to two results per byte; depends on rphp_pkg
`timescale 1ns / 1ps

module rphp_core #(
  parameter int MAX_RESOURCES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output rphp_pkg::result_t res0,
  output rphp_pkg::result_t res1,
  output logic [1:0]        res_cnt
);

  logic [2:0]  phase_r, phase_nxt;
  logic        pend_r, pend_nxt;
  logic [1:0]  wbc_r, wbc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [31:0] pk_r, pk_nxt;
  logic [31:0] unp_r, unp_nxt;
  logic [31:0] nl_r, nl_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        flag_r, flag_nxt;
  logic [31:0] nstart_r, nstart_nxt;

  rphp_pkg::result_t rec, cor, done, main_res;
  logic        rec_vld, cor_vld;
  logic        skip_a, skip_b;
  logic [31:0] word, pos_p1, len;
  logic [1:0]  cnt;

  always_comb begin
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    wbc_nxt    = wbc_r;
    acc_nxt    = acc_r;
    idx_nxt    = idx_r;
    pk_nxt     = pk_r;
    unp_nxt    = unp_r;
    nl_nxt     = nl_r;
    skip_nxt   = skip_r;
    flag_nxt   = flag_r;
    nstart_nxt = nstart_r;
    pos_p1     = pos_r + 32'd1;
    pos_nxt    = pos_p1;
    rec        = '0;
    cor        = '0;
    done       = '0;
    rec_vld    = 1'b0;
    cor_vld    = 1'b0;
    skip_a     = 1'b0;
    skip_b     = 1'b0;
    len        = 32'd0;
    word       = acc_r | (32'(data_byte) << {wbc_r, 3'b000});

    case (phase_r)
      rphp_pkg::PH_SCAN: begin
        if (pend_r && data_byte == rphp_pkg::MARK_SECOND) begin
          phase_nxt = rphp_pkg::PH_INDEX;
          pend_nxt  = 1'b0;
          wbc_nxt   = 2'd0;
          acc_nxt   = 32'd0;
        end else begin
          skip_a   = pend_r;
          skip_b   = data_byte != rphp_pkg::MARK_FIRST;
          pend_nxt = data_byte == rphp_pkg::MARK_FIRST;
        end
        if (flag_r && (skip_a || skip_b)) begin
          cor_vld          = 1'b1;
          cor.event_offset = skip_a ? (pos_r - 32'd1) : pos_r;
          flag_nxt         = 1'b0;
        end
      end
      rphp_pkg::PH_INDEX, rphp_pkg::PH_PACKED, rphp_pkg::PH_UNPACKED,
      rphp_pkg::PH_NAMELEN: begin
        if (wbc_r != 2'd3) begin
          acc_nxt = word;
          wbc_nxt = wbc_r + 2'd1;
        end else begin
          wbc_nxt = 2'd0;
          acc_nxt = 32'd0;
          if (phase_r == rphp_pkg::PH_INDEX) begin
            idx_nxt   = word;
            phase_nxt = rphp_pkg::PH_PACKED;
          end else if (phase_r == rphp_pkg::PH_PACKED) begin
            pk_nxt    = word;
            phase_nxt = rphp_pkg::PH_UNPACKED;
          end else if (phase_r == rphp_pkg::PH_UNPACKED) begin
            unp_nxt   = word;
            phase_nxt = rphp_pkg::PH_NAMELEN;
          end else begin
            nl_nxt     = word;
            nstart_nxt = pos_p1;
            len        = word[31] ? 32'd0 : word;
            skip_nxt   = len;
            phase_nxt  = (len != 32'd0) ? rphp_pkg::PH_NAME : rphp_pkg::PH_TERM;
          end
        end
      end
      rphp_pkg::PH_NAME: begin
        skip_nxt = skip_r - 32'd1;
        if (skip_r == 32'd1) begin
          phase_nxt = rphp_pkg::PH_TERM;
        end
      end
      rphp_pkg::PH_TERM: begin
        rec_vld             = 1'b1;
        rec.kind            = rphp_pkg::KIND_RECORD;
        rec.resource_index  = idx_r;
        rec.header_ok       = !idx_r[31] && (idx_r < 32'(MAX_RESOURCES)) &&
                              !pk_r[31] && !unp_r[31] && !nl_r[31];
        rec.packed_size     = pk_r;
        rec.unpacked_size   = unp_r;
        rec.name_length     = nl_r;
        rec.name_terminated = data_byte == 8'h00;
        rec.name_offset     = nstart_r;
        rec.payload_offset  = pos_p1;
        flag_nxt            = 1'b1;
        len                 = unp_r[31] ? 32'd0 : unp_r;
        skip_nxt            = len;
        phase_nxt = (len != 32'd0) ? rphp_pkg::PH_PAYLOAD : rphp_pkg::PH_SCAN;
      end
      default: begin
        skip_nxt = skip_r - 32'd1;
        if (skip_r == 32'd1) begin
          phase_nxt = rphp_pkg::PH_SCAN;
        end
      end
    endcase

    done.kind         = rphp_pkg::KIND_DONE;
    done.event_offset = pos_p1;
    done.last_of_run  = 1'b1;

    if (last_byte) begin
      // dangling marker byte at the end of the package
      if (phase_nxt == rphp_pkg::PH_SCAN && pend_nxt && flag_nxt) begin
        cor_vld          = 1'b1;
        cor.event_offset = pos_r;
      end
      phase_nxt  = rphp_pkg::PH_SCAN;
      pend_nxt   = 1'b0;
      wbc_nxt    = 2'd0;
      acc_nxt    = 32'd0;
      idx_nxt    = 32'd0;
      pk_nxt     = 32'd0;
      unp_nxt    = 32'd0;
      nl_nxt     = 32'd0;
      skip_nxt   = 32'd0;
      pos_nxt    = 32'd0;
      flag_nxt   = 1'b1;
      nstart_nxt = 32'd0;
    end

    cor.kind = rphp_pkg::KIND_CORRUPT;
    main_res = rec_vld ? rec : cor;
    main_res.last_of_run = !last_byte;

    if (rec_vld || cor_vld) begin
      res0 = main_res;
      res1 = done;
      cnt  = last_byte ? 2'd2 : 2'd1;
    end else begin
      res0 = done;
      res1 = '0;
      cnt  = last_byte ? 2'd1 : 2'd0;
    end
  end

  assign res_cnt = go ? cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rphp_pkg::PH_SCAN;
      pend_r   <= 1'b0;
      wbc_r    <= 2'd0;
      acc_r    <= 32'd0;
      idx_r    <= 32'd0;
      pk_r     <= 32'd0;
      unp_r    <= 32'd0;
      nl_r     <= 32'd0;
      skip_r   <= 32'd0;
      pos_r    <= 32'd0;
      flag_r   <= 1'b1;
      nstart_r <= 32'd0;
    end else if (go) begin
      phase_r  <= phase_nxt;
      pend_r   <= pend_nxt;
      wbc_r    <= wbc_nxt;
      acc_r    <= acc_nxt;
      idx_r    <= idx_nxt;
      pk_r     <= pk_nxt;
      unp_r    <= unp_nxt;
      nl_r     <= nl_nxt;
      skip_r   <= skip_nxt;
      pos_r    <= pos_nxt;
      flag_r   <= flag_nxt;
      nstart_r <= nstart_nxt;
    end
  end

endmodule

[design/rphp_result_fifo.sv]
// rphp_result_fifo: four-entry result queue taking up to two requests per cycle
// decouples the parser from output stall; depends on rphp_pkg
`timescale 1ns / 1ps

module rphp_result_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  rphp_pkg::result_t push0,
  input  rphp_pkg::result_t push1,
  input  logic [1:0]        push_cnt,
  output logic              has_room,
  output logic              out_vld,
  input  logic              pop,
  output rphp_pkg::result_t head
);

  localparam int PtrW = $clog2(rphp_pkg::FIFO_DEPTH);

  rphp_pkg::result_t mem_r [rphp_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_p1;
  logic [PtrW:0]   cnt_r, cnt_nxt;
  logic            do_pop;

  assign do_pop   = pop && out_vld;
  assign out_vld  = cnt_r != '0;
  assign has_room = cnt_r <= (PtrW + 1)'(rphp_pkg::FIFO_DEPTH - 2);
  assign head     = mem_r[rp_r];
  assign wp_p1    = wp_r + PtrW'(1);

  always_comb begin
    wp_nxt  = wp_r + PtrW'(push_cnt);
    rp_nxt  = do_pop ? rp_r + PtrW'(1) : rp_r;
    cnt_nxt = cnt_r + (PtrW + 1)'(push_cnt) - (PtrW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wp_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wp_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/resource_package_header_parser_unit.sv]
// resource_package_header_parser_unit: top level of the header parser
// input register, rphp_core and rphp_result_fifo; depends on rphp_pkg
//
// usage: package bytes enter on the in_ channel, one request per byte, with
// in_last_byte set on the final byte. results leave on the out_ channel: a
// record per header (at its terminator byte), a corruption event for the
// first stray byte after the start or after a record, and a done result
// after the last byte. one byte can cause up to two results.
// throughput: one byte per cycle while results are taken and the queue has room;
// a byte that causes two results is absorbed by the four-entry result queue.
// an accepted byte is held in the input register, parsed by rphp_core once
// the result queue has room, and its results are written into the result
// queue, whose head drives out_.
// in_stall rises when a byte is held and the result queue has fewer than two free entries.
// when out_stall is high the head result holds and the queue fills.
// reset (rst_n low, synchronous) empties the queue and returns the parser
// to scanning at byte offset zero.
`timescale 1ns / 1ps

module resource_package_header_parser_unit #(
  parameter int MAX_RESOURCES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [31:0] out_resource_index,
  output logic               out_header_ok,
  output logic signed [31:0] out_packed_size,
  output logic signed [31:0] out_unpacked_size,
  output logic signed [31:0] out_name_length,
  output logic               out_name_terminated,
  output logic [31:0]        out_name_offset,
  output logic [31:0]        out_payload_offset,
  output logic [31:0]        out_event_offset,
  output logic               out_last_of_run
);

  logic              vld_r;
  logic [7:0]        data_r;
  logic              last_r;
  logic              go, has_room;
  logic [1:0]        res_cnt;
  rphp_pkg::result_t res0, res1, head;

  assign go       = vld_r && has_room;
  assign in_stall = vld_r && !has_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  rphp_core #(
    .MAX_RESOURCES(MAX_RESOURCES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .data_byte(data_r),
    .last_byte(last_r),
    .res0     (res0),
    .res1     (res1),
    .res_cnt  (res_cnt)
  );

  rphp_result_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push0   (res0),
    .push1   (res1),
    .push_cnt(res_cnt),
    .has_room(has_room),
    .out_vld (out_valid),
    .pop     (!out_stall),
    .head    (head)
  );

  assign out_kind            = head.kind;
  assign out_resource_index  = head.resource_index;
  assign out_header_ok       = head.header_ok;
  assign out_packed_size     = head.packed_size;
  assign out_unpacked_size   = head.unpacked_size;
  assign out_name_length     = head.name_length;
  assign out_name_terminated = head.name_terminated;
  assign out_name_offset     = head.name_offset;
  assign out_payload_offset  = head.payload_offset;
  assign out_event_offset    = head.event_offset;
  assign out_last_of_run     = head.last_of_run;

endmodule

[design/rphp_checker.sv]
// rphp_checker: port-level assertions for resource_package_header_parser_unit
// attached by bind at the end of this file; depends on rphp_pkg
`timescale 1ns / 1ps

module rphp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [31:0] out_event_offset,
  input logic        out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind != 2'd3)
    else $error("illegal result kind");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == rphp_pkg::KIND_DONE |-> out_last_of_run)
    else $error("done result not last of run");

  a_record_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == rphp_pkg::KIND_RECORD |-> out_event_offset == 32'd0)
    else $error("record carries an event offset");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind resource_package_header_parser_unit rphp_checker u_rphp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_event_offset(out_event_offset),
  .out_last_of_run (out_last_of_run)
);

[tb/sv/resource_package_header_parser_unit_tb.sv]
// resource_package_header_parser_unit_tb: self-checking testbench for the header parser
// streams packages byte by byte and checks every record and event against a predictor
// depends on rphp_pkg and resource_package_header_parser_unit
`timescale 1ns / 1ps

module resource_package_header_parser_unit_tb;

  localparam int MAX_RES     = 256;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 4000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_data_byte;
  logic               in_last_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_kind;
  logic signed [31:0] out_resource_index;
  logic               out_header_ok;
  logic signed [31:0] out_packed_size;
  logic signed [31:0] out_unpacked_size;
  logic signed [31:0] out_name_length;
  logic               out_name_terminated;
  logic [31:0]        out_name_offset;
  logic [31:0]        out_payload_offset;
  logic [31:0]        out_event_offset;
  logic               out_last_of_run;

  resource_package_header_parser_unit #(
    .MAX_RESOURCES(MAX_RES)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_resource_index (out_resource_index),
    .out_header_ok      (out_header_ok),
    .out_packed_size    (out_packed_size),
    .out_unpacked_size  (out_unpacked_size),
    .out_name_length    (out_name_length),
    .out_name_terminated(out_name_terminated),
    .out_name_offset    (out_name_offset),
    .out_payload_offset (out_payload_offset),
    .out_event_offset   (out_event_offset),
    .out_last_of_run    (out_last_of_run)
  );

  // parser model state
  logic [2:0]  st_phase;
  logic        st_mark;
  logic [1:0]  st_wcnt;
  logic [31:0] st_word;
  logic [31:0] st_index;
  logic [31:0] st_packed;
  logic [31:0] st_unpacked;
  logic [31:0] st_namelen;
  logic [31:0] st_skip;
  logic [31:0] st_pos;
  logic        st_fresh;
  logic [31:0] st_name_at;

  rphp_pkg::result_t predicted_results[$];
  rphp_pkg::result_t byte_results[$];
  logic [7:0]        pkg_bytes[$];

  int  err_count;
  int  n_bytes;
  int  n_predicted;
  int  n_records;
  int  n_corrupt;
  int  n_done;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%08h expected 0x%08h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic reset_parser_model();
    st_phase    = rphp_pkg::PH_SCAN;
    st_mark     = 1'b0;
    st_wcnt     = 2'd0;
    st_word     = 32'd0;
    st_index    = 32'd0;
    st_packed   = 32'd0;
    st_unpacked = 32'd0;
    st_namelen  = 32'd0;
    st_skip     = 32'd0;
    st_pos      = 32'd0;
    st_fresh    = 1'b1;
    st_name_at  = 32'd0;
  endtask

  task automatic add_event(input logic [1:0] kind, input logic [31:0] offset);
    rphp_pkg::result_t r;
    r              = '0;
    r.kind         = kind;
    r.event_offset = offset;
    byte_results.push_back(r);
  endtask

  task automatic note_stray(input logic [31:0] offset);
    if (st_fresh) begin
      st_fresh = 1'b0;
      add_event(rphp_pkg::KIND_CORRUPT, offset);
    end
  endtask

  task automatic scan_plain(input logic [7:0] b, input logic [31:0] offset);
    if (b == rphp_pkg::MARK_FIRST) st_mark = 1'b1;
    else note_stray(offset);
  endtask

  // expected results caused by one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [31:0]       pos;
    rphp_pkg::result_t r;
    pos = st_pos;
    case (st_phase)
      rphp_pkg::PH_SCAN: begin
        if (st_mark) begin
          st_mark = 1'b0;
          if (b == rphp_pkg::MARK_SECOND) begin
            st_phase = rphp_pkg::PH_INDEX;
            st_wcnt  = 2'd0;
            st_word  = 32'd0;
          end else begin
            note_stray(pos - 32'd1);
            scan_plain(b, pos);
          end
        end else begin
          scan_plain(b, pos);
        end
      end
      rphp_pkg::PH_INDEX, rphp_pkg::PH_PACKED, rphp_pkg::PH_UNPACKED,
      rphp_pkg::PH_NAMELEN: begin
        st_word = st_word | ({24'd0, b} << (8 * st_wcnt));
        if (st_wcnt != 2'd3) begin
          st_wcnt = st_wcnt + 2'd1;
        end else begin
          st_wcnt = 2'd0;
          if (st_phase == rphp_pkg::PH_INDEX) begin
            st_index = st_word;
            st_phase = rphp_pkg::PH_PACKED;
          end else if (st_phase == rphp_pkg::PH_PACKED) begin
            st_packed = st_word;
            st_phase  = rphp_pkg::PH_UNPACKED;
          end else if (st_phase == rphp_pkg::PH_UNPACKED) begin
            st_unpacked = st_word;
            st_phase    = rphp_pkg::PH_NAMELEN;
          end else begin
            st_namelen = st_word;
            st_name_at = pos + 32'd1;
            st_skip    = st_namelen[31] ? 32'd0 : st_namelen;
            st_phase   = (st_skip != 32'd0) ? rphp_pkg::PH_NAME : rphp_pkg::PH_TERM;
          end
          st_word = 32'd0;
        end
      end
      rphp_pkg::PH_NAME: begin
        st_skip = st_skip - 32'd1;
        if (st_skip == 32'd0) st_phase = rphp_pkg::PH_TERM;
      end
      rphp_pkg::PH_TERM: begin
        r                 = '0;
        r.kind            = rphp_pkg::KIND_RECORD;
        r.resource_index  = st_index;
        r.header_ok       = !st_index[31] && (st_index < 32'(MAX_RES)) && !st_packed[31] &&
                            !st_unpacked[31] && !st_namelen[31];
        r.packed_size     = st_packed;
        r.unpacked_size   = st_unpacked;
        r.name_length     = st_namelen;
        r.name_terminated = (b == 8'd0);
        r.name_offset     = st_name_at;
        r.payload_offset  = pos + 32'd1;
        byte_results.push_back(r);
        st_fresh = 1'b1;
        st_skip  = st_unpacked[31] ? 32'd0 : st_unpacked;
        st_phase = (st_skip != 32'd0) ? rphp_pkg::PH_PAYLOAD : rphp_pkg::PH_SCAN;
      end
      default: begin
        st_skip = st_skip - 32'd1;
        if (st_skip == 32'd0) st_phase = rphp_pkg::PH_SCAN;
      end
    endcase
    st_pos = pos + 32'd1;
    if (last) begin
      if (st_phase == rphp_pkg::PH_SCAN && st_mark) begin
        st_mark = 1'b0;
        note_stray(pos);
      end
      add_event(rphp_pkg::KIND_DONE, pos + 32'd1);
      reset_parser_model();
    end
    if (byte_results.size() > 0) begin
      r             = byte_results.pop_back();
      r.last_of_run = 1'b1;
      byte_results.push_back(r);
    end
    foreach (byte_results[i]) predicted_results.push_back(byte_results[i]);
    n_predicted += byte_results.size();
    byte_results.delete();
  endtask

  // one request on the input channel
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    parse_byte(b, last);
    n_bytes++;
  endtask

  task automatic send_package();
    foreach (pkg_bytes[i]) send_byte(pkg_bytes[i], i == pkg_bytes.size() - 1);
    pkg_bytes.delete();
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) pkg_bytes.push_back(w[8*i +: 8]);
  endtask

  // name or payload lengths over 12 end the package inside the name or the payload
  task automatic add_header(input logic [31:0] idx, input logic [31:0] pk,
                            input logic [31:0] up, input logic [31:0] nl,
                            input logic [7:0] term, output bit truncated);
    int unsigned n;
    truncated = 0;
    pkg_bytes.push_back(rphp_pkg::MARK_FIRST);
    pkg_bytes.push_back(rphp_pkg::MARK_SECOND);
    add_word(idx);
    add_word(pk);
    add_word(up);
    add_word(nl);
    n = nl[31] ? 0 : nl;
    if (n > 12) begin
      repeat ($urandom_range(0, 6)) pkg_bytes.push_back(8'($urandom));
      truncated = 1;
      return;
    end
    repeat (n) pkg_bytes.push_back(8'($urandom));
    pkg_bytes.push_back(term);
    n = up[31] ? 0 : up;
    if (n > 12) begin
      repeat ($urandom_range(0, 6)) pkg_bytes.push_back(8'($urandom));
      truncated = 1;
      return;
    end
    repeat (n) pkg_bytes.push_back(8'($urandom));
  endtask

  function automatic logic [31:0] pick_index();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'(MAX_RES - 1);
      2:       return 32'(MAX_RES);
      3:       return $urandom_range(0, 300);
      4:       return {1'b1, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_packed();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(0, 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : {1'b1, 31'($urandom)};
      1:       return ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : $urandom_range(13, 1000);
      default: return $urandom_range(0, 5);
    endcase
  endfunction

  // mostly well-formed headers, with noise, broken markers and truncation mixed in
  task automatic build_random_package();
    bit       truncated;
    int       segs;
    logic [7:0] term;
    truncated = 0;
    segs      = $urandom_range(1, 3);
    for (int s = 0; s < segs && !truncated; s++) begin
      case ($urandom_range(0, 9))
        7: begin
          repeat ($urandom_range(1, 4))
            pkg_bytes.push_back(($urandom_range(0, 3) == 0) ? rphp_pkg::MARK_FIRST :
                                8'($urandom));
        end
        8: begin
          pkg_bytes.push_back(rphp_pkg::MARK_FIRST);
          pkg_bytes.push_back(8'($urandom_range(2, 255)));
        end
        9: begin
          pkg_bytes.push_back(rphp_pkg::MARK_FIRST);
          pkg_bytes.push_back(rphp_pkg::MARK_SECOND);
          repeat ($urandom_range(0, 15)) pkg_bytes.push_back(8'($urandom));
          truncated = 1;
        end
        default: begin
          term = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd0;
          add_header(pick_index(), pick_packed(), pick_length(), pick_length(), term,
                     truncated);
        end
      endcase
    end
    if (!truncated && $urandom_range(0, 7) == 0) pkg_bytes.push_back(rphp_pkg::MARK_FIRST);
    if (pkg_bytes.size() == 0) pkg_bytes.push_back(8'($urandom));
  endtask

  task automatic test_directed_cases();
    bit truncated;
    // stray byte, broken marker, header with negative lengths, stray, marker at end
    pkg_bytes.push_back(8'h55);
    pkg_bytes.push_back(rphp_pkg::MARK_FIRST);
    pkg_bytes.push_back(8'h02);
    add_header(32'(MAX_RES - 1), 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, truncated);
    pkg_bytes.push_back(8'hFF);
    pkg_bytes.push_back(rphp_pkg::MARK_FIRST);
    send_package();
    pkg_bytes.push_back(rphp_pkg::MARK_FIRST);
    send_package();
  endtask

  task automatic test_random_packages();
    int start_bytes;
    tx_idle_on  = 1;
    rx_idle_on  = 1;
    start_bytes = n_bytes;
    while (n_bytes - start_bytes < 45) begin
      build_random_package();
      send_package();
    end
  endtask

  // receiver holds off while one-byte packages keep the result queue full
  task automatic test_result_backpressure();
    logic [7:0] b;
    tx_idle_on   = 0;
    hold_request = 1;
    repeat (24) begin
      b = 8'($urandom);
      if (b == rphp_pkg::MARK_FIRST) b = 8'h00;
      pkg_bytes.push_back(b);
      send_package();
    end
  endtask

  task automatic test_streaming_no_idle();
    int start_bytes;
    tx_idle_on  = 0;
    rx_idle_on  = 0;
    start_bytes = n_bytes;
    while (n_bytes - start_bytes < 20) begin
      build_random_package();
      send_package();
    end
  endtask

  // receiver side: random stall bursts and the long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    rphp_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("unexpected result kind", 32'(out_kind), 32'd0);
      end else begin
        want = predicted_results.pop_front();
        check_field("kind", 32'(out_kind), 32'(want.kind));
        check_field("resource_index", out_resource_index, want.resource_index);
        check_field("header_ok", 32'(out_header_ok), 32'(want.header_ok));
        check_field("packed_size", out_packed_size, want.packed_size);
        check_field("unpacked_size", out_unpacked_size, want.unpacked_size);
        check_field("name_length", out_name_length, want.name_length);
        check_field("name_terminated", 32'(out_name_terminated), 32'(want.name_terminated));
        check_field("name_offset", out_name_offset, want.name_offset);
        check_field("payload_offset", out_payload_offset, want.payload_offset);
        check_field("event_offset", out_event_offset, want.event_offset);
        check_field("last_of_run", 32'(out_last_of_run), 32'(want.last_of_run));
      end
      case (out_kind)
        rphp_pkg::KIND_RECORD:  n_records++;
        rphp_pkg::KIND_CORRUPT: n_corrupt++;
        default:                n_done++;
      endcase
    end
  end

  // watchdog on cycles with no request moving on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'd0;
    in_last_byte = 1'b0;
    err_count    = 0;
    n_bytes      = 0;
    n_predicted  = 0;
    n_records    = 0;
    n_corrupt    = 0;
    n_done       = 0;
    tx_idle_on   = 1;
    rx_idle_on   = 1;
    hold_request = 0;
    reset_parser_model();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_random_packages();
    test_result_backpressure();
    test_streaming_no_idle();

    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    foreach (predicted_results[i])
      report_mismatch("missing result kind", 32'd0, 32'(predicted_results[i].kind));

    $display("streamed %0d bytes: %0d records, %0d corruption events, %0d done results",
             n_bytes, n_records, n_corrupt, n_done);
    $display("covered stray bytes, broken markers, negative and truncated lengths, stalls");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
